### rtl/core/fpse_pkg.sv
// Shared types and constants for the Fenwick prefix-sum engine.
// Holds request codes, field widths and the controller/datapath command and status structs.
// No dependencies.
package fpse_pkg;

	localparam int REQ_W   = 2;
	localparam int POS_W   = 10;
	localparam int DELTA_W = 16;
	localparam int SUM_W   = 32;

	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	typedef struct packed {
		logic load;
		logic walk;
		logic accum;
		logic wback;
		logic clr_wr;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic walk_busy;
		logic clr_last;
	} dp_status_t;

endpackage

### rtl/core/fpse_datapath.sv
// Datapath of the Fenwick prefix-sum engine: cell memory, walk position,
// accumulator, clear counter and result register.
// Depends on fpse_pkg.
module fpse_datapath #(
	parameter int TREE_SIZE = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  fpse_pkg::dp_cmd_t                    cmd,
	output fpse_pkg::dp_status_t                 status,
	input  logic [fpse_pkg::REQ_W-1:0]           req_type,
	input  logic [fpse_pkg::POS_W-1:0]           position,
	input  logic signed [fpse_pkg::DELTA_W-1:0]  delta,
	output logic signed [fpse_pkg::SUM_W-1:0]    prefix_total
);
	import fpse_pkg::*;

	localparam int AW = $clog2(TREE_SIZE);
	localparam int WW = ((AW > POS_W) ? AW : POS_W) + 1;
	localparam logic [WW-1:0] LAST_POS = WW'(TREE_SIZE - 1);
	localparam logic [WW-1:0] SIZE_POS = WW'(TREE_SIZE);
	localparam logic [AW-1:0] LAST_IDX = AW'(TREE_SIZE - 1);

	logic [SUM_W-1:0] mem [TREE_SIZE];
	logic [SUM_W-1:0] rd_q;
	logic             rd_v_q;
	logic [AW-1:0]    pend_q;
	logic [WW-1:0]    walk_q;
	logic [SUM_W-1:0] acc_q;
	logic [SUM_W-1:0] amount_q;
	logic [AW-1:0]    clr_q;
	logic [SUM_W-1:0] total_q;

	logic [WW-1:0]    pos_ext;
	logic [WW-1:0]    load_walk;
	logic [WW-1:0]    low_bit;
	logic [WW-1:0]    next_walk;
	logic             active;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [SUM_W-1:0] mem_wd;

	always_comb begin
		pos_ext = WW'(position);
		unique case (req_type)
			REQ_QUERY: load_walk = (pos_ext > LAST_POS) ? LAST_POS : pos_ext;
			REQ_ADD:   load_walk = pos_ext;
			default:   load_walk = '0;
		endcase
	end

	assign active    = (walk_q != '0) && (walk_q < SIZE_POS);
	assign low_bit   = walk_q & (~walk_q + WW'(1));
	assign next_walk = cmd.accum ? (walk_q & (walk_q - WW'(1))) : (walk_q + low_bit);

	assign mem_we = cmd.clr_wr || (cmd.wback && rd_v_q);
	assign mem_wa = cmd.clr_wr ? clr_q : pend_q;
	assign mem_wd = cmd.clr_wr ? '0 : (rd_q + amount_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd.walk && active) begin
			rd_q <= mem[walk_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
			clr_q  <= '0;
		end else begin
			rd_v_q <= cmd.walk && active;
			if (cmd.load) begin
				clr_q <= '0;
			end else if (cmd.clr_wr) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			walk_q   <= load_walk;
			acc_q    <= '0;
			amount_q <= {{(SUM_W - DELTA_W){delta[DELTA_W-1]}}, delta};
		end else if (cmd.walk) begin
			if (active) begin
				walk_q <= next_walk;
				pend_q <= walk_q[AW-1:0];
			end
			if (cmd.accum && rd_v_q) begin
				acc_q <= acc_q + rd_q;
			end
		end
		if (cmd.emit) begin
			total_q <= acc_q;
		end
	end

	assign status.walk_busy = active || rd_v_q;
	assign status.clr_last  = (clr_q == LAST_IDX);
	assign prefix_total     = total_q;

endmodule

### rtl/core/fpse_ctrl.sv
// Controller of the Fenwick prefix-sum engine: sequences the reset sweep,
// request decode, tree walks, clear sweeps and result hand-off.
// Depends on fpse_pkg.
module fpse_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  logic [fpse_pkg::REQ_W-1:0]  req_type,
	output logic                        rsp_valid,
	input  logic                        rsp_stall,
	output fpse_pkg::dp_cmd_t           cmd,
	input  fpse_pkg::dp_status_t        status
);
	import fpse_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_CLEAR = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t           state_q;
	state_t           state_d;
	logic [REQ_W-1:0] kind_q;
	logic             out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_INIT: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_type) inside
						REQ_QUERY, REQ_ADD: state_d = ST_WALK;
						REQ_CLEAR:          state_d = ST_CLEAR;
						default:            state_d = ST_FIN;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk  = 1'b1;
				cmd.accum = (kind_q == REQ_QUERY);
				cmd.wback = (kind_q == REQ_ADD);
				if (!status.walk_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !rsp_stall) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			kind_q      <= REQ_QUERY;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				kind_q <= req_type;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = out_valid_q;

endmodule

### rtl/core/fenwick_prefix_sum_engine_unit.sv
// Fenwick prefix-sum engine: one request at a time, one result per request.
// Query or add: a tree walk over k cells, k at most log2(TREE_SIZE), which may be empty;
// one cell access a cycle sets the pace.
// Clear: one cell zeroed per cycle. Unknown request: goes straight to result hand-off.
// After reset req_stall stays high while every cell is zeroed.
// Depends on fpse_pkg, fpse_ctrl and fpse_datapath.
module fenwick_prefix_sum_engine_unit #(
	parameter int TREE_SIZE = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	output logic                                 req_stall,
	input  logic [fpse_pkg::REQ_W-1:0]           req_type,
	input  logic [fpse_pkg::POS_W-1:0]           position,
	input  logic signed [fpse_pkg::DELTA_W-1:0]  delta,
	output logic                                 rsp_valid,
	input  logic                                 rsp_stall,
	output logic signed [fpse_pkg::SUM_W-1:0]    prefix_total
);
	import fpse_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	fpse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.status    (status)
	);

	fpse_datapath #(
		.TREE_SIZE (TREE_SIZE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.req_type     (req_type),
		.position     (position),
		.delta        (delta),
		.prefix_total (prefix_total)
	);

endmodule

### rtl/core/fpse_checker.sv
// Port-level checker for the Fenwick prefix-sum engine, bound to the top level.
// Tracks items in flight and checks results against acceptances.
// Depends on fenwick_prefix_sum_engine_unit.
module fpse_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] prefix_total
);

	logic [1:0] pending_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 2'd0;
		end else begin
			pending_q <= pending_q + {1'b0, req_acc} - {1'b0, rsp_acc};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(prefix_total))
		else $error("Stalled result item changed.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> req_stall)
		else $error("Item accepted while previous item still in work.");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("Result item without an accepted item.");

	a_in_flight_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("More than two items in flight.");

endmodule

bind fenwick_prefix_sum_engine_unit fpse_checker u_fpse_checker (.*);
